/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Antecedent implies consequent in the same cycle, outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* hdl/ngfc_pkg.sv */
// ----------------------------------------------------------------------------
// ngfc_pkg
// Types and constants of the n-gram frequency counter.
// ----------------------------------------------------------------------------
package ngfc_pkg;

    localparam int unsigned KEY_W   = 64;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned WBYTES_W = 4;
    localparam logic [WBYTES_W-1:0] WBYTES_RESET = 4'd8;

    // Hash round constants
    localparam logic [63:0] MUL_C0 = 64'd1830293841;
    localparam logic [63:0] MUL_C1 = 64'd309574038479;
    localparam logic [63:0] MUL_C2 = 64'd409856720348563;
    localparam logic [63:0] XOR_C0 = 64'd20947602394;
    localparam logic [63:0] XOR_C1 = 64'd20956749875;

    // Round index of the hash
    localparam logic [1:0] ROUND_0    = 2'd0;
    localparam logic [1:0] ROUND_1    = 2'd1;
    localparam logic [1:0] ROUND_LAST = 2'd2;

    // Partial-product step within one 64x64 multiply
    localparam logic [1:0] STEP_LL  = 2'd0;
    localparam logic [1:0] STEP_LH  = 2'd1;
    localparam logic [1:0] STEP_HL  = 2'd2;
    localparam logic [1:0] STEP_FIN = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
    } slot_t;

    function automatic logic [63:0] mul_const(input logic [1:0] round);
        logic [63:0] c;
        case (round)
            ROUND_0: c = MUL_C0;
            ROUND_1: c = MUL_C1;
            ROUND_LAST: c = MUL_C2;
            default: c = MUL_C0;
        endcase
        return c;
    endfunction

    function automatic logic [63:0] xor_const(input logic [1:0] round);
        logic [63:0] c;
        case (round)
            ROUND_0: c = XOR_C0;
            ROUND_1: c = XOR_C1;
            default: c = '0;
        endcase
        return c;
    endfunction

    // Keep the newest n bytes; 0 acts as 1, anything above 8 as 8.
    function automatic logic [KEY_W-1:0] win_mask(input logic [WBYTES_W-1:0] n);
        logic [WBYTES_W-1:0] n_eff;
        logic [KEY_W-1:0]    m;
        n_eff = (n == '0) ? WBYTES_W'(1) : n;
        for (int i = 0; i < 8; i++) begin
            m[8*i +: 8] = (WBYTES_W'(i) < n_eff) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

/* hdl/ngfc_hash.sv */
// ----------------------------------------------------------------------------
// ngfc_hash
// Three-round multiplicative hash over one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ngfc_hash (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] key,
    output logic        done,
    output logic [63:0] hash
);

    logic        busy_reg;
    logic        done_reg;
    logic [1:0]  round_reg;
    logic [1:0]  step_reg;
    logic [63:0] h_reg;
    logic [63:0] acc_reg;
    logic [63:0] prod_reg;

    logic [63:0] cst;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [63:0] prod_next;
    logic [63:0] acc_sum;

    assign cst = ngfc_pkg::mul_const(round_reg);

    // Cross terms only matter in their low 32 bits (product is mod 2^64).
    always_comb begin
        case (step_reg)
            ngfc_pkg::STEP_LH: begin
                op_a = h_reg[31:0];
                op_b = cst[63:32];
            end
            ngfc_pkg::STEP_HL: begin
                op_a = h_reg[63:32];
                op_b = cst[31:0];
            end
            default: begin
                op_a = h_reg[31:0];
                op_b = cst[31:0];
            end
        endcase
    end

    assign prod_next = op_a * op_b;
    assign acc_sum   = acc_reg + {prod_reg[31:0], 32'h0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            round_reg <= ngfc_pkg::ROUND_0;
            step_reg  <= ngfc_pkg::STEP_LL;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                round_reg <= ngfc_pkg::ROUND_0;
                step_reg  <= ngfc_pkg::STEP_LL;
            end else if (busy_reg) begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == ngfc_pkg::STEP_FIN) begin
                    if (round_reg == ngfc_pkg::ROUND_LAST) begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end else begin
                        round_reg <= round_reg + 2'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            h_reg <= key;
        end else if (busy_reg) begin
            prod_reg <= prod_next;
            case (step_reg)
                ngfc_pkg::STEP_LH: acc_reg <= prod_reg;
                ngfc_pkg::STEP_HL: acc_reg <= acc_sum;
                ngfc_pkg::STEP_FIN: h_reg <= acc_sum ^ ngfc_pkg::xor_const(round_reg);
                default: acc_reg <= acc_reg;
            endcase
        end
    end

    assign done = done_reg;
    assign hash = h_reg;

    `ASSERT_IMPLIES(a_done_idle, aclk, aresetn, done_reg, !busy_reg)
    `ASSERT_CLK(a_start_busy, aclk, aresetn, start |=> busy_reg)
    `ASSERT_CLK(a_last_done, aclk, aresetn,
        busy_reg && !start && step_reg == ngfc_pkg::STEP_FIN &&
        round_reg == ngfc_pkg::ROUND_LAST |=> done_reg)

endmodule

/* hdl/ngram_frequency_counter.sv */
// ----------------------------------------------------------------------------
// ngram_frequency_counter
// Counts each window of recent stream bytes in a linear-probing hash table
// and reports the most frequent window.
// ----------------------------------------------------------------------------
//  channel  | ports                           | direction | per transaction
//  ---------+---------------------------------+-----------+-----------------
//  s_       | s_valid s_ready s_data_byte     | in        | one stream byte
//  m_       | m_valid m_ready m_window_key .. | out       | one result
//  cfg_     | cfg_wr_en cfg_wr_data           | in        | window_bytes
//
//  After reset the table is swept to zero, slot by slot, with s_ready low.
//  Per byte: accept, hash (three 64-bit multiplies, four steps each on the
//  shared 32x32 multiplier, then the home slot is handed over), one probe
//  step per probed slot (up to PROBE_LIMIT+1), best-update (skipped on a
//  drop) and result load. The probe loop is set by the one table read port.
//  A waiting result does not block the next accept; a stalled m_ side holds
//  the block only at result load.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ngram_frequency_counter #(
    parameter int unsigned TABLE_SIZE_LOG2 = 16,
    parameter int unsigned PROBE_LIMIT     = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_window_key,
    output logic [31:0] m_key_count,
    output logic [31:0] m_best_count,
    output logic [63:0] m_best_key,
    output logic        m_table_full
);

    localparam int unsigned SLOTS = 2 ** TABLE_SIZE_LOG2;
    localparam int unsigned ADV_W = $clog2(PROBE_LIMIT + 1);
    localparam logic [ADV_W-1:0] ADV_LAST = ADV_W'(PROBE_LIMIT);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_HASH  = 6'b000100,
        S_PROBE = 6'b001000,
        S_BEST  = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t                      state_reg;
    logic [TABLE_SIZE_LOG2-1:0]  clr_reg;
    logic [TABLE_SIZE_LOG2-1:0]  slot_reg;
    logic [ADV_W-1:0]            adv_reg;
    logic [3:0]                  wbytes_reg;
    logic [63:0]                 window_reg;
    logic [31:0]                 cnt_reg;
    logic [31:0]                 best_cnt_reg;
    logic [63:0]                 best_key_reg;
    logic                        full_reg;
    logic                        m_valid_reg;

    ngfc_pkg::slot_t             mem [SLOTS];
    ngfc_pkg::slot_t             rd_data_reg;
    logic [TABLE_SIZE_LOG2-1:0]  rd_addr;
    logic [TABLE_SIZE_LOG2-1:0]  wr_addr;
    ngfc_pkg::slot_t             wr_data;
    logic                        wr_en;

    logic                        accept;
    logic                        hash_done;
    logic [63:0]                 hash_val;
    logic [63:0]                 window_next;
    logic                        hit;
    logic [31:0]                 cnt_inc;
    logic                        out_free;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign window_next = {window_reg[55:0], s_data_byte} & ngfc_pkg::win_mask(wbytes_reg);

    ngfc_hash u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .key     (window_next),
        .done    (hash_done),
        .hash    (hash_val)
    );

    // Slot matches if it holds this key or is empty.
    assign hit     = (rd_data_reg.key == window_reg) || (rd_data_reg.count == '0);
    assign cnt_inc = (rd_data_reg.count == '1) ? rd_data_reg.count
                                               : rd_data_reg.count + 32'd1;

    always_comb begin
        case (state_reg)
            S_HASH:  rd_addr = hash_val[TABLE_SIZE_LOG2-1:0];
            S_PROBE: rd_addr = slot_reg + 1'b1;
            default: rd_addr = slot_reg;
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = slot_reg;
        wr_data = '{key: window_reg, count: cnt_inc};
        if (state_reg == S_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = clr_reg;
            wr_data = '0;
        end else if (state_reg == S_PROBE && hit) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            wbytes_reg   <= ngfc_pkg::WBYTES_RESET;
            window_reg   <= '0;
            best_cnt_reg <= '0;
            best_key_reg <= '0;
            full_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                wbytes_reg <= cfg_wr_data;
            end
            if (m_valid_reg && m_ready && !(state_reg == S_OUT && out_free)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == '1) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        window_reg <= window_next;
                        state_reg  <= S_HASH;
                    end
                end
                S_HASH: begin
                    if (hash_done) begin
                        state_reg <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    if (hit) begin
                        state_reg <= S_BEST;
                    end else if (adv_reg == ADV_LAST) begin
                        // drop the transaction: table and best stay as they are
                        full_reg  <= 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_BEST: begin
                    if (cnt_reg > best_cnt_reg) begin
                        best_cnt_reg <= cnt_reg;
                        best_key_reg <= window_reg;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_HASH: begin
                slot_reg <= hash_val[TABLE_SIZE_LOG2-1:0];
                adv_reg  <= '0;
            end
            S_PROBE: begin
                if (hit) begin
                    cnt_reg <= cnt_inc;
                end else if (adv_reg == ADV_LAST) begin
                    cnt_reg <= '0;
                end else begin
                    slot_reg <= slot_reg + 1'b1;
                    adv_reg  <= adv_reg + 1'b1;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    m_window_key <= window_reg;
                    m_key_count  <= cnt_reg;
                    m_best_count <= best_cnt_reg;
                    m_best_key   <= best_key_reg;
                    m_table_full <= full_reg;
                end
            end
            default: slot_reg <= slot_reg;
        endcase
    end

    assign m_valid = m_valid_reg;

    `ASSERT_CLK(a_best_mono, aclk, aresetn,
        $past(aresetn) |-> (best_cnt_reg >= $past(best_cnt_reg)))
    `ASSERT_CLK(a_full_sticky, aclk, aresetn,
        $past(aresetn) && $past(full_reg) |-> full_reg)
    `ASSERT_CLK(a_drop_sets_full, aclk, aresetn,
        state_reg == S_PROBE && !hit && adv_reg == ADV_LAST |=> full_reg && cnt_reg == '0)
    `ASSERT_IMPLIES(a_no_write_busy, aclk, aresetn,
        wr_en, state_reg == S_CLEAR || state_reg == S_PROBE)

endmodule

/* verif/ngram_frequency_counter_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ngram_frequency_counter_tb
// Streams bytes into the n-gram counter and checks every result against a
// bit-accurate software copy of the hash table, window and best tracking.
// Covers the reset window length, ties, window length clamping, random
// streams under several lengths, and a cluster that wraps the table end and
// is grown until the probe limit is hit.
// ----------------------------------------------------------------------------
module ngram_frequency_counter_tb;

    localparam int unsigned KEY_W        = ngfc_pkg::KEY_W;
    localparam int unsigned COUNT_W      = ngfc_pkg::COUNT_W;
    localparam int unsigned WBYTES_W     = ngfc_pkg::WBYTES_W;
    localparam int unsigned TBL_LOG2     = 16;
    localparam int unsigned SLOTS        = 1 << TBL_LOG2;
    localparam int unsigned PROBE_MAX    = 1024;
    localparam logic [63:0] HASH_M0      = 64'd1830293841;
    localparam logic [63:0] HASH_X0      = 64'd20947602394;
    localparam logic [63:0] HASH_M1      = 64'd309574038479;
    localparam logic [63:0] HASH_X1      = 64'd20956749875;
    localparam logic [63:0] HASH_M2      = 64'd409856720348563;
    localparam int          SETTLE_CYCLES = 24;
    localparam int          RANDOM_ITEMS = 700;
    localparam int          STEADY_ITEMS = 300;
    localparam int          TIMEOUT_NS   = 300_000_000;
    // Cluster placed so that it wraps past the last slot
    localparam logic [TBL_LOG2-1:0] CLUSTER_BASE = TBL_LOG2'(SLOTS - 512);
    localparam int unsigned CLUSTER_SPAN = PROBE_MAX + 1;

    typedef struct packed {
        logic [KEY_W-1:0]   window_key;
        logic [COUNT_W-1:0] key_count;
        logic [COUNT_W-1:0] best_count;
        logic [KEY_W-1:0]   best_key;
        logic               table_full;
    } ngram_result_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [WBYTES_W-1:0] cfg_wr_data;
    logic                s_valid;
    logic                s_ready;
    logic [7:0]          s_data_byte;
    logic                m_valid;
    logic                m_ready;
    logic [63:0]         m_window_key;
    logic [31:0]         m_key_count;
    logic [31:0]         m_best_count;
    logic [63:0]         m_best_key;
    logic                m_table_full;

    ngram_frequency_counter #(
        .TABLE_SIZE_LOG2(TBL_LOG2),
        .PROBE_LIMIT    (PROBE_MAX)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_window_key(m_window_key),
        .m_key_count (m_key_count),
        .m_best_count(m_best_count),
        .m_best_key  (m_best_key),
        .m_table_full(m_table_full)
    );

    // Software copy of the block state
    bit [KEY_W-1:0]    slot_key_m [SLOTS];
    bit [COUNT_W-1:0]  slot_cnt_m [SLOTS];
    bit [KEY_W-1:0]    window_m;
    bit [KEY_W-1:0]    best_key_m;
    bit [COUNT_W-1:0]  best_cnt_m;
    bit                full_m;
    bit [WBYTES_W-1:0] wbytes_m = ngfc_pkg::WBYTES_RESET;

    ngram_result_t pending_results [$];
    int            mismatch_count = 0;
    bit            src_gaps_on    = 1'b1;
    bit            sink_stalls_on = 1'b1;

    function automatic bit [TBL_LOG2-1:0] home_slot(input bit [KEY_W-1:0] key);
        bit [63:0] h;
        h = key * HASH_M0;
        h = h ^ HASH_X0;
        h = h * HASH_M1;
        h = h ^ HASH_X1;
        h = h * HASH_M2;
        return h[TBL_LOG2-1:0];
    endfunction

    function automatic bit [KEY_W-1:0] window_keep_mask(input bit [WBYTES_W-1:0] n);
        bit [WBYTES_W-1:0] n_eff;
        n_eff = (n == '0) ? WBYTES_W'(1) : n;
        if (n_eff >= 8) return '1;
        return (64'd1 << (8 * n_eff)) - 64'd1;
    endfunction

    // Shift one byte into the window, count the window, return the result.
    function automatic ngram_result_t tally_byte(input bit [7:0] b);
        ngram_result_t     r;
        bit [TBL_LOG2-1:0] slot;
        int unsigned       advanced;
        bit                found;
        window_m = ((window_m << 8) | KEY_W'(b)) & window_keep_mask(wbytes_m);
        slot     = home_slot(window_m);
        advanced = 0;
        found    = 1'b1;
        while (found && slot_key_m[slot] != window_m && slot_cnt_m[slot] != '0) begin
            // one more advance would pass the limit: drop the window
            if (advanced == PROBE_MAX) begin
                found = 1'b0;
            end else begin
                slot     = slot + 1'b1;
                advanced = advanced + 1;
            end
        end
        r.key_count = '0;
        if (found) begin
            slot_key_m[slot] = window_m;
            if (slot_cnt_m[slot] != '1) slot_cnt_m[slot] = slot_cnt_m[slot] + 1'b1;
            r.key_count = slot_cnt_m[slot];
            if (r.key_count > best_cnt_m) begin
                best_cnt_m = r.key_count;
                best_key_m = window_m;
            end
        end else begin
            full_m = 1'b1;
        end
        r.window_key = window_m;
        r.best_count = best_cnt_m;
        r.best_key   = best_key_m;
        r.table_full = full_m;
        return r;
    endfunction

    function automatic bit key_stored(input bit [KEY_W-1:0] key);
        bit [TBL_LOG2-1:0] slot;
        slot = home_slot(key);
        for (int n = 0; n < SLOTS; n++) begin
            if (slot_cnt_m[slot] == '0) return 1'b0;
            if (slot_key_m[slot] == key) return 1'b1;
            slot = slot + 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit cluster_full();
        bit [TBL_LOG2-1:0] slot;
        for (int i = 0; i < CLUSTER_SPAN; i++) begin
            slot = TBL_LOG2'(CLUSTER_BASE + i);
            if (slot_cnt_m[slot] == '0) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Byte whose new window homes inside the cluster at or before its last
    // empty slot, so that it lands in the cluster, or -1.
    function automatic int fill_byte();
        bit [KEY_W-1:0]    key;
        bit [TBL_LOG2-1:0] h;
        bit [TBL_LOG2-1:0] off;
        bit [TBL_LOG2-1:0] slot;
        bit [7:0]          b;
        int                start;
        int                last_free;
        last_free = -1;
        for (int i = 0; i < CLUSTER_SPAN; i++) begin
            slot = TBL_LOG2'(CLUSTER_BASE + i);
            if (slot_cnt_m[slot] == '0) last_free = i;
        end
        start = $urandom_range(0, 255);
        for (int i = 0; i < 256; i++) begin
            b   = 8'(start + i);
            key = ((window_m << 8) | KEY_W'(b)) & window_keep_mask(wbytes_m);
            h   = home_slot(key);
            off = h - CLUSTER_BASE;
            if (int'(off) <= last_free && !key_stored(key)) return int'(b);
        end
        return -1;
    endfunction

    // Two bytes whose second window is new and homes at the target, or -1.
    function automatic int find_pair(input bit [TBL_LOG2-1:0] target);
        bit [KEY_W-1:0] first_key;
        bit [KEY_W-1:0] second_key;
        bit [KEY_W-1:0] keep;
        keep = window_keep_mask(wbytes_m);
        for (int p = 0; p < 65536; p++) begin
            first_key  = ((window_m << 8) | KEY_W'(p[15:8])) & keep;
            second_key = ((first_key << 8) | KEY_W'(p[7:0])) & keep;
            if (home_slot(second_key) == target && second_key != first_key
                    && !key_stored(second_key))
                return p;
        end
        return -1;
    endfunction

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result sink: ready with random stall bursts
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (sink_stalls_on && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_results
        ngram_result_t got;
        ngram_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got.window_key = m_window_key;
            got.key_count  = m_key_count;
            got.best_count = m_best_count;
            got.best_key   = m_best_key;
            got.table_full = m_table_full;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: key %h count %0d best %0d/%h full %0b",
                             got.window_key, got.key_count, got.best_count,
                             got.best_key, got.table_full);
            end else begin
                want = pending_results.pop_front();
                if (got.window_key !== want.window_key || got.key_count !== want.key_count
                        || got.best_count !== want.best_count
                        || got.best_key !== want.best_key
                        || got.table_full !== want.table_full) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"result mismatch: expected key %h count %0d best %0d/%h ",
                                  "full %0b, got key %h count %0d best %0d/%h full %0b"},
                                 want.window_key, want.key_count, want.best_count,
                                 want.best_key, want.table_full, got.window_key,
                                 got.key_count, got.best_count, got.best_key,
                                 got.table_full);
                end
            end
        end
    end

    task automatic send_byte(input bit [7:0] b);
        if (src_gaps_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(tally_byte(b));
    endtask

    // Drop valid, wait for all results, then let the block settle.
    task automatic finish_phase();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_window_bytes(input bit [WBYTES_W-1:0] n);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= n;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        wbytes_m   = n;
    endtask

    task automatic random_segment(input int n_items);
        bit [7:0] alphabet [4];
        int       pick;
        finish_phase();
        pick = $urandom_range(0, 9);
        if (pick == 0) write_window_bytes(4'd0);
        else if (pick == 1) write_window_bytes(4'($urandom_range(9, 15)));
        else write_window_bytes(4'($urandom_range(1, 8)));
        foreach (alphabet[i]) alphabet[i] = 8'($urandom_range(0, 255));
        // small alphabet builds repeats and collisions, the rest is noise
        repeat (n_items) begin
            if ($urandom_range(0, 9) < 6) send_byte(alphabet[$urandom_range(0, 3)]);
            else send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Window length out of reset, extremes of the byte.
    task automatic test_reset_window();
        send_byte(8'h00);
        repeat (9) send_byte(8'hFF);
        send_byte(8'h00);
        finish_phase();
    endtask

    task automatic test_ties();
        write_window_bytes(4'd1);
        repeat (3) begin
            send_byte(8'h5A);
            send_byte(8'hA5);
        end
        finish_phase();
    endtask

    // Zero acts as one, above eight acts as eight.
    task automatic test_window_clamp();
        write_window_bytes(4'd0);
        send_byte(8'h5A);
        send_byte(8'h0F);
        finish_phase();
        write_window_bytes(4'd15);
        send_byte(8'h01);
        send_byte(8'h80);
        send_byte(8'hFE);
        finish_phase();
        write_window_bytes(4'd9);
        send_byte(8'h7F);
        send_byte(8'hC3);
        finish_phase();
    endtask

    task automatic test_random_stream();
        int remaining;
        int seg;
        remaining = RANDOM_ITEMS - STEADY_ITEMS;
        while (remaining > 0) begin
            seg = $urandom_range(40, 200);
            if (seg > remaining) seg = remaining;
            src_gaps_on    = ($urandom_range(0, 2) != 0);
            sink_stalls_on = ($urandom_range(0, 2) != 0);
            random_segment(seg);
            remaining -= seg;
        end
        finish_phase();
    endtask

    task automatic aim_at(input int unsigned offset);
        bit [TBL_LOG2-1:0] target;
        bit                hit;
        int                pair;
        target = TBL_LOG2'(CLUSTER_BASE + offset);
        hit    = 1'b0;
        for (int tries = 0; tries < 16 && !hit; tries++) begin
            pair = find_pair(target);
            if (pair >= 0) begin
                send_byte(pair[15:8]);
                send_byte(pair[7:0]);
                hit = 1'b1;
            end else begin
                send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Fill a wrapping run of PROBE_MAX+1 slots, then probe across it: a new
    // key homed one slot in lands just past the run, one homed at its start
    // is dropped and sets the sticky flag.
    task automatic test_probe_limit();
        int guard;
        int pick;
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        finish_phase();
        write_window_bytes(4'd3);
        guard = 0;
        while (!cluster_full() && guard < 20000) begin
            pick = fill_byte();
            if (pick >= 0) send_byte(8'(pick));
            else send_byte(8'($urandom_range(0, 255)));
            guard++;
        end
        aim_at(1);
        aim_at(0);
        aim_at(0);
        finish_phase();
    endtask

    task automatic test_steady_stream();
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
        random_segment(STEADY_ITEMS);
        finish_phase();
    endtask

    initial begin
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_valid     <= 1'b0;
        s_data_byte <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_window();
        test_ties();
        test_window_clamp();
        test_random_stream();
        test_probe_limit();
        test_steady_stream();

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/ngfc_pkg.sv
hdl/ngfc_hash.sv
hdl/ngram_frequency_counter.sv
verif/ngram_frequency_counter_tb.sv
